FILE: design/prs_pkg.sv
package prs_pkg;

	localparam int POP_SIZE_DEF = 64;
	localparam int ID_BITS_DEF  = 16;

	localparam int OBJ_W   = 32;
	localparam int FIT_W   = 16;
	localparam int DRAW_W  = 16;
	localparam int FUNC_W  = 3;
	localparam int ST_W    = 3;
	localparam int DIV_Q_W = 25;
	localparam int DIV_C_W = 5;

	localparam logic [FUNC_W-1:0] F_ADD    = 3'd0;
	localparam logic [FUNC_W-1:0] F_REMOVE = 3'd1;
	localparam logic [FUNC_W-1:0] F_UPDATE = 3'd2;
	localparam logic [FUNC_W-1:0] F_PICK   = 3'd3;
	localparam logic [FUNC_W-1:0] F_CLEAR  = 3'd4;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
	localparam logic [ST_W-1:0] ST_NOID     = 3'd2;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
	localparam logic [ST_W-1:0] ST_DEGEN    = 3'd4;
	localparam logic [ST_W-1:0] ST_PICKFAIL = 3'd5;

	localparam logic CFG_MODE  = 1'b0;
	localparam logic CFG_WORST = 1'b1;

	localparam logic [FIT_W-1:0] WORST_FIT_RST = 16'd655;

	localparam logic signed [OBJ_W-1:0] OBJ_MAXV = 32'sh7fff_ffff;
	localparam logic signed [OBJ_W-1:0] OBJ_MINV = 32'sh8000_0000;

	// quotient bits below the binary point of the dividend
	localparam logic [DIV_C_W-1:0] DIV_SH_LIN  = 5'd16;
	localparam logic [DIV_C_W-1:0] DIV_SH_QUAD = 5'd24;

	typedef struct packed {
		logic start;
		logic wide;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [DIV_Q_W-1:0]  quot;
	} div_rsp_t;

	function automatic logic [FIT_W-1:0] sat_fit(input logic [DIV_Q_W-1:0] q);
		sat_fit = (|q[DIV_Q_W-1:FIT_W]) ? {FIT_W{1'b1}} : q[FIT_W-1:0];
	endfunction

endpackage

FILE: design/prs_div.sv
module prs_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  prs_pkg::div_req_t         req,
	input  logic [prs_pkg::OBJ_W-1:0] dvd,
	input  logic [prs_pkg::OBJ_W-1:0] dvs,
	output prs_pkg::div_rsp_t         rsp
);
	import prs_pkg::*;

	// floor(dvd * 2^shift / dvs), dividend never above divisor, one bit a cycle
	logic [OBJ_W-1:0]   rem_q;
	logic [OBJ_W-1:0]   dvs_q;
	logic [DIV_Q_W-1:0] q_q;
	logic [DIV_C_W-1:0] cnt_q;
	logic               busy_q;
	logic               first_q;
	logic               done_q;
	logic [OBJ_W:0]     ext;
	logic [OBJ_W:0]     diff;
	logic               ge;

	always_comb begin
		ext  = first_q ? {1'b0, rem_q} : {rem_q, 1'b0};
		ge   = ext >= {1'b0, dvs_q};
		diff = ext - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			first_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
				cnt_q   <= req.wide ? DIV_SH_QUAD : DIV_SH_LIN;
			end else if (busy_q) begin
				first_q <= 1'b0;
				cnt_q   <= cnt_q - DIV_C_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= dvd;
			dvs_q <= dvs;
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[OBJ_W-1:0] : ext[OBJ_W-1:0];
			q_q   <= {q_q[DIV_Q_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = q_q;

endmodule

FILE: design/population_roulette_selector_core.sv
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    func, entry_id, objective, random_draw
// out      output     out_valid/out_ready  status, result_id, fitness, probability,
//                                          entry_count, best_id, worst_id, last
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// add and clear go from idle straight to the out state; remove, pick and rescan read one entry
// at a time. update runs a fitness pass and then a probability pass over all entries,
// both through the one-bit-a-cycle divider that the two passes share.
// reset empties the table; the entry memory itself is not cleared.
// a new item is taken only when the sequencer is idle; a stalled out beat holds it.
module population_roulette_selector_core #(
	parameter int POP_SIZE = prs_pkg::POP_SIZE_DEF,
	parameter int ID_BITS  = prs_pkg::ID_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [prs_pkg::FUNC_W-1:0]          func,
	input  logic [ID_BITS-1:0]                  entry_id,
	input  logic signed [prs_pkg::OBJ_W-1:0]    objective,
	input  logic [prs_pkg::DRAW_W-1:0]          random_draw,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [prs_pkg::ST_W-1:0]            status,
	output logic [ID_BITS-1:0]                  result_id,
	output logic [prs_pkg::FIT_W-1:0]           fitness,
	output logic [prs_pkg::FIT_W-1:0]           probability,
	output logic [$clog2(POP_SIZE+1)-1:0]       entry_count,
	output logic [ID_BITS-1:0]                  best_id,
	output logic [ID_BITS-1:0]                  worst_id,
	output logic                                last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [prs_pkg::FIT_W-1:0]           cfg_data
);
	import prs_pkg::*;

	localparam int IDX_W = $clog2(POP_SIZE);
	localparam int CNT_W = $clog2(POP_SIZE + 1);
	localparam int SUM_W = FIT_W + IDX_W;
	localparam int F_LO  = FIT_W;
	localparam int O_LO  = 2 * FIT_W;
	localparam int I_LO  = 2 * FIT_W + OBJ_W;
	localparam int EW    = I_LO + ID_BITS;
	localparam int SQ_W  = 2 * DIV_Q_W - FIT_W - 1;
	localparam int MQ_W  = FIT_W + 1 + SQ_W;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_OUT      = 3'd1;
	localparam logic [2:0] S_RM_FIND  = 3'd2;
	localparam logic [2:0] S_RM_SHIFT = 3'd3;
	localparam logic [2:0] S_RESCAN   = 3'd4;
	localparam logic [2:0] S_UP1      = 3'd5;
	localparam logic [2:0] S_UP2      = 3'd6;
	localparam logic [2:0] S_PICK     = 3'd7;

	localparam logic [2:0] PH0 = 3'd0;
	localparam logic [2:0] PH1 = 3'd1;
	localparam logic [2:0] PH2 = 3'd2;
	localparam logic [2:0] PH3 = 3'd3;
	localparam logic [2:0] PH4 = 3'd4;
	localparam logic [2:0] PH5 = 3'd5;

	// entry memory: {id, objective, fitness, probability}
	logic [EW-1:0]    mem [POP_SIZE];
	logic [EW-1:0]    rdata;
	logic [EW-1:0]    wdata;
	logic [IDX_W-1:0] raddr;
	logic [IDX_W-1:0] waddr;
	logic             we;

	logic [2:0]                 state_q;
	logic [2:0]                 ph_q;
	logic [IDX_W-1:0]           idx_q;
	logic [CNT_W-1:0]           count_q;
	logic signed [OBJ_W-1:0]    min_v_q;
	logic signed [OBJ_W-1:0]    max_v_q;
	logic [ID_BITS-1:0]         min_id_q;
	logic [ID_BITS-1:0]         max_id_q;
	logic                       mode_q;
	logic [FIT_W-1:0]           wf_q;
	logic [ID_BITS-1:0]         key_q;
	logic [DRAW_W-1:0]          draw_q;
	logic [ST_W-1:0]            res_st_q;
	logic [ID_BITS-1:0]         res_id_q;
	logic [OBJ_W-1:0]           range_q;
	logic [SUM_W-1:0]           sum_q;
	logic [SUM_W-1:0]           acc_q;
	logic [EW-1:0]              word_q;
	logic [DIV_Q_W-1:0]         t_q;
	logic [SQ_W-1:0]            sq_q;
	logic [MQ_W-1:0]            mq_q;
	logic [FIT_W-1:0]           prob_q;

	logic                       out_valid_q;
	logic [ST_W-1:0]            status_q;
	logic [ID_BITS-1:0]         result_id_q;
	logic [FIT_W-1:0]           fitness_q;
	logic [FIT_W-1:0]           prob_out_q;
	logic [CNT_W-1:0]           entry_count_q;
	logic [ID_BITS-1:0]         best_id_q;
	logic [ID_BITS-1:0]         worst_id_q;
	logic                       last_q;

	logic [ID_BITS-1:0]         rd_id;
	logic signed [OBJ_W-1:0]    rd_obj;
	logic [FIT_W-1:0]           rd_fit;
	logic [FIT_W-1:0]           rd_prob;
	logic [IDX_W-1:0]           idx_p1;
	logic                       last_idx;
	logic                       out_free;
	logic                       out_load;
	logic [OBJ_W:0]             d_w;
	logic [OBJ_W:0]             rng_w;
	logic [FIT_W-1:0]           e_eff;
	logic [2*DIV_Q_W-1:0]       tt;
	logic [FIT_W+1:0]           quad_sum;
	logic [FIT_W-1:0]           quad_fit;
	logic [FIT_W-1:0]           fit_new;
	logic                       fit_wr;
	logic [SUM_W-1:0]           sum_n;
	logic [SUM_W-1:0]           acc_n;
	div_req_t                   div_req;
	div_rsp_t                   div_rsp;
	logic [OBJ_W-1:0]           div_dvd;
	logic [OBJ_W-1:0]           div_dvs;

	prs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.dvd    (div_dvd),
		.dvs    (div_dvs),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

	always_comb begin
		rd_id    = rdata[EW-1:I_LO];
		rd_obj   = rdata[I_LO-1:O_LO];
		rd_fit   = rdata[O_LO-1:F_LO];
		rd_prob  = rdata[F_LO-1:0];
		idx_p1   = idx_q + IDX_W'(1);
		last_idx = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
		out_free = !out_valid_q || out_ready;
		out_load = out_free && ((state_q == S_OUT) || ((state_q == S_UP2) && (ph_q == PH3)));
		d_w      = {max_v_q[OBJ_W-1], max_v_q} - {rd_obj[OBJ_W-1], rd_obj};
		rng_w    = {max_v_q[OBJ_W-1], max_v_q} - {min_v_q[OBJ_W-1], min_v_q};
		e_eff    = (wf_q == '0) ? FIT_W'(1) : wf_q;
		tt       = t_q * t_q;
		quad_sum = {2'b00, e_eff} + (FIT_W+2)'(mq_q >> 32);
		quad_fit = (quad_sum > (FIT_W+2)'({FIT_W{1'b1}})) ? {FIT_W{1'b1}}
			: quad_sum[FIT_W-1:0];
		fit_new  = (ph_q == PH5) ? quad_fit : sat_fit(div_rsp.quot);
		fit_wr   = (state_q == S_UP1) && (((ph_q == PH2) && div_rsp.done && !mode_q)
			|| (ph_q == PH5));
		sum_n    = sum_q + SUM_W'(fit_new);
		acc_n    = acc_q + SUM_W'(rd_prob);

		div_req.start = ((state_q == S_UP1) || (state_q == S_UP2)) && (ph_q == PH1);
		div_req.wide  = (state_q == S_UP1) && mode_q;
		div_dvd       = (state_q == S_UP1) ? d_w[OBJ_W-1:0] : OBJ_W'(rd_fit);
		div_dvs       = (state_q == S_UP1) ? range_q : OBJ_W'(sum_q);
	end

	always_comb begin
		raddr = (state_q == S_RM_SHIFT) ? idx_p1 : idx_q;
		we    = 1'b0;
		waddr = idx_q;
		wdata = rdata;
		if (state_q == S_IDLE) begin
			we    = in_valid && (func == F_ADD) && (count_q < CNT_W'(POP_SIZE));
			waddr = count_q[IDX_W-1:0];
			wdata = {entry_id, objective, {FIT_W{1'b0}}, {FIT_W{1'b0}}};
		end else if (state_q == S_RM_SHIFT) begin
			we = (ph_q == PH1);
		end else if (state_q == S_UP1) begin
			we    = fit_wr;
			wdata = {word_q[EW-1:O_LO], fit_new, word_q[F_LO-1:0]};
		end else if (state_q == S_UP2) begin
			we    = (ph_q == PH3) && out_free;
			wdata = {word_q[EW-1:F_LO], prob_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			wf_q   <= WORST_FIT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MODE:  mode_q <= cfg_data[0];
				CFG_WORST: wf_q   <= cfg_data;
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ph_q          <= PH0;
			idx_q         <= '0;
			count_q       <= '0;
			min_v_q       <= OBJ_MAXV;
			max_v_q       <= OBJ_MINV;
			min_id_q      <= '0;
			max_id_q      <= '0;
			key_q         <= '0;
			draw_q        <= '0;
			res_st_q      <= ST_OK;
			res_id_q      <= '0;
			range_q       <= '0;
			sum_q         <= '0;
			acc_q         <= '0;
			word_q        <= '0;
			t_q           <= '0;
			sq_q          <= '0;
			mq_q          <= '0;
			prob_q        <= '0;
			status_q      <= ST_OK;
			result_id_q   <= '0;
			fitness_q     <= '0;
			prob_out_q    <= '0;
			entry_count_q <= '0;
			best_id_q     <= '0;
			worst_id_q    <= '0;
			last_q        <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						key_q  <= entry_id;
						draw_q <= random_draw;
						idx_q  <= '0;
						ph_q   <= PH0;
						sum_q  <= '0;
						acc_q  <= '0;
						case (func)
							F_ADD: begin
								res_id_q <= entry_id;
								state_q  <= S_OUT;
								if (count_q < CNT_W'(POP_SIZE)) begin
									res_st_q <= ST_OK;
									count_q  <= count_q + CNT_W'(1);
									if ((count_q == '0) || (objective > max_v_q)) begin
										max_v_q  <= objective;
										max_id_q <= entry_id;
									end
									if ((count_q == '0) || (objective < min_v_q)) begin
										min_v_q  <= objective;
										min_id_q <= entry_id;
									end
								end else begin
									res_st_q <= ST_FULL;
								end
							end
							F_REMOVE: begin
								res_id_q <= entry_id;
								if (count_q == '0) begin
									res_st_q <= ST_EMPTY;
									state_q  <= S_OUT;
								end else begin
									res_st_q <= ST_OK;
									state_q  <= S_RM_FIND;
								end
							end
							F_UPDATE: begin
								res_id_q <= '0;
								if (count_q == '0) begin
									res_st_q <= ST_EMPTY;
									state_q  <= S_OUT;
								end else if (max_v_q <= min_v_q) begin
									// all-zero objectives also land here
									res_st_q <= ST_DEGEN;
									state_q  <= S_OUT;
								end else begin
									res_st_q <= ST_OK;
									range_q  <= rng_w[OBJ_W-1:0];
									state_q  <= S_UP1;
								end
							end
							F_PICK: begin
								res_id_q <= '0;
								if (count_q == '0) begin
									res_st_q <= ST_EMPTY;
									state_q  <= S_OUT;
								end else begin
									res_st_q <= ST_OK;
									state_q  <= S_PICK;
								end
							end
							F_CLEAR: begin
								res_st_q <= ST_OK;
								res_id_q <= '0;
								count_q  <= '0;
								min_v_q  <= OBJ_MAXV;
								max_v_q  <= OBJ_MINV;
								min_id_q <= '0;
								max_id_q <= '0;
								state_q  <= S_OUT;
							end
							default: ;
						endcase
					end
				end
				S_OUT: begin
					if (out_free) begin
						status_q      <= res_st_q;
						result_id_q   <= res_id_q;
						fitness_q     <= '0;
						prob_out_q    <= '0;
						entry_count_q <= count_q;
						best_id_q     <= min_id_q;
						worst_id_q    <= max_id_q;
						last_q        <= 1'b1;
						state_q       <= S_IDLE;
					end
				end
				S_RM_FIND: begin
					if (ph_q == PH0) begin
						ph_q <= PH1;
					end else if (rd_id == key_q) begin
						ph_q    <= PH0;
						state_q <= S_RM_SHIFT;
					end else if (last_idx) begin
						res_st_q <= ST_NOID;
						state_q  <= S_OUT;
					end else begin
						idx_q <= idx_p1;
						ph_q  <= PH0;
					end
				end
				S_RM_SHIFT: begin
					if (ph_q == PH0) begin
						if (last_idx) begin
							count_q <= count_q - CNT_W'(1);
							if ((count_q == CNT_W'(1)) || (key_q == max_id_q)
								|| (key_q == min_id_q)) begin
								min_v_q  <= OBJ_MAXV;
								max_v_q  <= OBJ_MINV;
								min_id_q <= '0;
								max_id_q <= '0;
							end
							if ((count_q != CNT_W'(1)) && ((key_q == max_id_q)
								|| (key_q == min_id_q))) begin
								idx_q   <= '0;
								state_q <= S_RESCAN;
							end else begin
								state_q <= S_OUT;
							end
						end else begin
							ph_q <= PH1;
						end
					end else begin
						idx_q <= idx_p1;
						ph_q  <= PH0;
					end
				end
				S_RESCAN: begin
					if (ph_q == PH0) begin
						ph_q <= PH1;
					end else begin
						if ((idx_q == '0) || (rd_obj > max_v_q)) begin
							max_v_q  <= rd_obj;
							max_id_q <= rd_id;
						end
						if ((idx_q == '0) || (rd_obj < min_v_q)) begin
							min_v_q  <= rd_obj;
							min_id_q <= rd_id;
						end
						if (last_idx) begin
							state_q <= S_OUT;
						end else begin
							idx_q <= idx_p1;
							ph_q  <= PH0;
						end
					end
				end
				S_UP1: begin
					case (ph_q)
						PH0: ph_q <= PH1;
						PH1: begin
							word_q <= rdata;
							ph_q   <= PH2;
						end
						PH2: begin
							if (div_rsp.done) begin
								t_q  <= div_rsp.quot;
								ph_q <= mode_q ? PH3 : PH0;
							end
						end
						PH3: begin
							sq_q <= tt[SQ_W+FIT_W-1:FIT_W];
							ph_q <= PH4;
						end
						PH4: begin
							mq_q <= MQ_W'((FIT_W+1)'((FIT_W+1)'(1) << FIT_W)
								- (FIT_W+1)'(e_eff)) * MQ_W'(sq_q);
							ph_q <= PH5;
						end
						default: ph_q <= PH0;
					endcase
					if (fit_wr) begin
						sum_q <= sum_n;
						if (last_idx) begin
							idx_q <= '0;
							if (sum_n == '0) begin
								res_st_q <= ST_DEGEN;
								state_q  <= S_OUT;
							end else begin
								state_q <= S_UP2;
							end
						end else begin
							idx_q <= idx_p1;
						end
					end
				end
				S_UP2: begin
					case (ph_q)
						PH0: ph_q <= PH1;
						PH1: begin
							word_q <= rdata;
							ph_q   <= PH2;
						end
						PH2: begin
							if (div_rsp.done) begin
								prob_q <= sat_fit(div_rsp.quot);
								ph_q   <= PH3;
							end
						end
						default: begin
							if (out_free) begin
								status_q      <= ST_OK;
								result_id_q   <= word_q[EW-1:I_LO];
								fitness_q     <= word_q[O_LO-1:F_LO];
								prob_out_q    <= prob_q;
								entry_count_q <= count_q;
								best_id_q     <= min_id_q;
								worst_id_q    <= max_id_q;
								last_q        <= last_idx;
								ph_q          <= PH0;
								if (last_idx) begin
									state_q <= S_IDLE;
								end else begin
									idx_q <= idx_p1;
								end
							end
						end
					endcase
				end
				S_PICK: begin
					if (ph_q == PH0) begin
						ph_q <= PH1;
					end else begin
						acc_q <= acc_n;
						ph_q  <= PH0;
						if (SUM_W'(draw_q) < acc_n) begin
							res_id_q <= rd_id;
							state_q  <= S_OUT;
						end else if (last_idx) begin
							res_st_q <= ST_PICKFAIL;
							state_q  <= S_OUT;
						end else begin
							idx_q <= idx_p1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign result_id   = result_id_q;
	assign fitness     = fitness_q;
	assign probability = prob_out_q;
	assign entry_count = entry_count_q;
	assign best_id     = best_id_q;
	assign worst_id    = worst_id_q;
	assign last        = last_q;

endmodule
